// File: sv/mcbrb_pkg.sv
// Shared types and constants for the multi-channel byte ring buffers.
`default_nettype none
package mcbrb_pkg;

	localparam int KIND_W = 2;
	localparam int CHAN_W = 2;
	localparam int BYTE_W = 8;
	localparam int FILL_W = 10;

	typedef enum logic [KIND_W-1:0] {
		KIND_TX_PUSH = 2'd0,
		KIND_TX_POP  = 2'd1,
		KIND_RX_PUSH = 2'd2,
		KIND_RX_POP  = 2'd3
	} kind_t;

	// Memory enables issued by the control unit for one item.
	typedef struct packed {
		logic tx_we;
		logic tx_re;
		logic rx_we;
		logic rx_re;
	} mem_ctl_t;

	// Result fields held for the cycle after an item is accepted.
	typedef struct packed {
		logic              pop_valid;
		logic              push_dropped;
		logic              pop_empty;
		logic              pop_tx;
		logic [FILL_W-1:0] tx_fill;
		logic [FILL_W-1:0] rx_fill;
	} res_t;

endpackage
`default_nettype wire

// File: sv/multi_channel_byte_ring_buffers.sv
// Top level of the multi-channel transmit/receive byte ring buffers.
//
// Each channel owns a transmit ring and a receive ring of RING_DEPTH bytes,
// of which RING_DEPTH-1 can be filled. An item (kind, channel, push_byte) is
// taken at a rising edge with start high and busy low. busy stays low, so an
// item may be issued every cycle: one item per cycle sustained.
// The result appears in the cycle after the item is taken, on done for a single
// cycle, with pop_byte read from the byte RAM of the addressed ring (one
// registered RAM read). Pointers update at the accept edge, so the next item
// already sees them; a pop right after a push to the same slot reads the
// written byte since the RAM write lands on the earlier edge.
// A push into a full ring is dropped (push_dropped); a pop from an empty ring
// returns zero (pop_empty). tx_fill and rx_fill give both fills after the
// item. A channel number at or above CHANNELS does nothing and returns zeros.
// Reset clears all ring pointers at once; the byte RAMs are not cleared.
// The receiver cannot stall: every result is delivered on its done cycle.
`default_nettype none
module multi_channel_byte_ring_buffers import mcbrb_pkg::*; #(
	parameter int CHANNELS   = 4,
	parameter int RING_DEPTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [CHAN_W-1:0] channel,
	input  wire logic [BYTE_W-1:0] push_byte,
	output logic                   done,
	output logic [BYTE_W-1:0]      pop_byte,
	output logic                   pop_valid,
	output logic                   push_dropped,
	output logic                   pop_empty,
	output logic [FILL_W-1:0]      tx_fill,
	output logic [FILL_W-1:0]      rx_fill
);

	localparam int STORE_DEPTH = CHANNELS * RING_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	mem_ctl_t          mem_ctl;
	logic [ADDR_W-1:0] addr;
	logic [BYTE_W-1:0] tx_rdata, rx_rdata;
	res_t              res;
	logic              accept;

	// every item completes in one pass, so the block never holds off start
	assign busy   = 1'b0;
	assign accept = start && !busy;

	mcbrb_ctrl #(
		.CHANNELS   (CHANNELS),
		.RING_DEPTH (RING_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.kind    (kind),
		.channel (channel),
		.mem_ctl (mem_ctl),
		.addr    (addr),
		.done    (done),
		.res     (res)
	);

	mcbrb_store #(
		.DEPTH (STORE_DEPTH)
	) u_tx_store (
		.clk   (clk),
		.we    (mem_ctl.tx_we),
		.re    (mem_ctl.tx_re),
		.addr  (addr),
		.wdata (push_byte),
		.rdata (tx_rdata)
	);

	mcbrb_store #(
		.DEPTH (STORE_DEPTH)
	) u_rx_store (
		.clk   (clk),
		.we    (mem_ctl.rx_we),
		.re    (mem_ctl.rx_re),
		.addr  (addr),
		.wdata (push_byte),
		.rdata (rx_rdata)
	);

	assign pop_byte     = res.pop_valid ? (res.pop_tx ? tx_rdata : rx_rdata) : '0;
	assign pop_valid    = res.pop_valid;
	assign push_dropped = res.push_dropped;
	assign pop_empty    = res.pop_empty;
	assign tx_fill      = res.tx_fill;
	assign rx_fill      = res.rx_fill;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without an accepted item");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot0({pop_valid, push_dropped, pop_empty}))
		else $error("more than one status flag set on a result");

	a_byte_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (pop_byte != '0)) |-> pop_valid)
		else $error("pop byte nonzero without a valid pop");

endmodule
`default_nettype wire

// File: sv/mcbrb_store.sv
// Byte store: one synchronous RAM, one write and one registered read per cycle.
`default_nettype none
module mcbrb_store import mcbrb_pkg::*; #(
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [BYTE_W-1:0]        wdata,
	output logic [BYTE_W-1:0]             rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: sv/mcbrb_ctrl.sv
// Ring pointer registers, full/empty checks, memory requests and result register.
`default_nettype none
module mcbrb_ctrl import mcbrb_pkg::*; #(
	parameter int CHANNELS   = 4,
	parameter int RING_DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   accept,
	input  wire logic [KIND_W-1:0]                      kind,
	input  wire logic [CHAN_W-1:0]                      channel,
	output mem_ctl_t                                    mem_ctl,
	output logic [$clog2(CHANNELS*RING_DEPTH)-1:0]      addr,
	output logic                                        done,
	output res_t                                        res
);

	localparam int PTR_W    = $clog2(RING_DEPTH);
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W   = $clog2(CHANNELS*RING_DEPTH);
	localparam int CMP_W    = (CHAN_W > 5) ? CHAN_W : 5;

	logic [PTR_W-1:0] tx_wp_q [CHANNELS];
	logic [PTR_W-1:0] tx_rp_q [CHANNELS];
	logic [PTR_W-1:0] rx_wp_q [CHANNELS];
	logic [PTR_W-1:0] rx_rp_q [CHANNELS];

	logic [CH_IDX_W-1:0] ch_idx;
	logic                in_range;
	logic [PTR_W-1:0]    tx_wp, tx_rp, rx_wp, rx_rp;
	logic [PTR_W-1:0]    tx_wp_n, tx_rp_n, rx_wp_n, rx_rp_n;
	logic [PTR_W-1:0]    slot;
	mem_ctl_t            mc;
	res_t                res_d;
	res_t                res_s1;
	logic                done_s1;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [FILL_W-1:0] ring_fill(input logic [PTR_W-1:0] w,
			input logic [PTR_W-1:0] r);
		logic [PTR_W:0] d;
		d = {1'b0, w} - {1'b0, r};
		if (w < r) begin
			d = d + (PTR_W+1)'(RING_DEPTH);
		end
		return FILL_W'(d);
	endfunction

	assign ch_idx   = CH_IDX_W'(channel);
	assign in_range = CMP_W'(channel) < CMP_W'(CHANNELS);

	assign tx_wp = tx_wp_q[ch_idx];
	assign tx_rp = tx_rp_q[ch_idx];
	assign rx_wp = rx_wp_q[ch_idx];
	assign rx_rp = rx_rp_q[ch_idx];

	always_comb begin
		tx_wp_n = tx_wp;
		tx_rp_n = tx_rp;
		rx_wp_n = rx_wp;
		rx_rp_n = rx_rp;
		slot    = tx_wp;
		mc      = '0;
		res_d   = '0;
		case (kind_t'(kind))
			KIND_TX_PUSH: begin
				slot = tx_wp;
				if (ring_next(tx_wp) == tx_rp) begin
					res_d.push_dropped = 1'b1;
				end else begin
					mc.tx_we = 1'b1;
					tx_wp_n  = ring_next(tx_wp);
				end
			end
			KIND_TX_POP: begin
				slot         = tx_rp;
				res_d.pop_tx = 1'b1;
				if (tx_wp == tx_rp) begin
					res_d.pop_empty = 1'b1;
				end else begin
					mc.tx_re        = 1'b1;
					res_d.pop_valid = 1'b1;
					tx_rp_n         = ring_next(tx_rp);
				end
			end
			KIND_RX_PUSH: begin
				slot = rx_wp;
				if (ring_next(rx_wp) == rx_rp) begin
					res_d.push_dropped = 1'b1;
				end else begin
					mc.rx_we = 1'b1;
					rx_wp_n  = ring_next(rx_wp);
				end
			end
			KIND_RX_POP: begin
				slot = rx_rp;
				if (rx_wp == rx_rp) begin
					res_d.pop_empty = 1'b1;
				end else begin
					mc.rx_re        = 1'b1;
					res_d.pop_valid = 1'b1;
					rx_rp_n         = ring_next(rx_rp);
				end
			end
			default: begin
				mc = '0;
			end
		endcase
		res_d.tx_fill = ring_fill(tx_wp_n, tx_rp_n);
		res_d.rx_fill = ring_fill(rx_wp_n, rx_rp_n);
		// drop everything for a channel that does not exist, and the memory requests when no item is taken
		if (!(accept && in_range)) begin
			mc = '0;
		end
		if (!in_range) begin
			res_d = '0;
		end
	end

	assign mem_ctl = mc;
	assign addr    = ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH) + ADDR_W'(slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				tx_wp_q[i] <= '0;
				tx_rp_q[i] <= '0;
				rx_wp_q[i] <= '0;
				rx_rp_q[i] <= '0;
			end
		end else if (accept && in_range) begin
			tx_wp_q[ch_idx] <= tx_wp_n;
			tx_rp_q[ch_idx] <= tx_rp_n;
			rx_wp_q[ch_idx] <= rx_wp_n;
			rx_rp_q[ch_idx] <= rx_rp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	assign done = done_s1;
	assign res  = res_s1;

endmodule
`default_nettype wire
